// ----- sv/psi_pkg.sv -----
// shared constants, payload types and helpers for the plane segment intersect block
`default_nettype none
package psi_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CW          = COORD_WIDTH;
  // exact plane distance width: three full products plus the shifted offset
  localparam int DW          = 2 * CW + 3;
  localparam int PW          = CW + DW;
  localparam int NCH         = (DW + CW - 1) / CW;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int NUM_REGS    = 4;
  localparam int DATA_W      = (CW > 32) ? 64 : 32;
  localparam int STRIDE_BITS = (CW > 32) ? 3 : 2;
  localparam int ADDR_W      = $clog2(NUM_REGS) + STRIDE_BITS;

  typedef enum logic [1:0] {
    REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z, REG_PLANE_OFFSET
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_HIT, ST_ON_PLANE, ST_OFF_PLANE, ST_OUTSIDE
  } status_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } segment_t;

  typedef struct packed {
    coord_t  start_distance;
    coord_t  end_distance;
    logic    crosses;
    coord_t  hit_x;
    coord_t  hit_y;
    coord_t  hit_z;
    status_t status;
    logic    saturated;
  } result_t;

  typedef struct packed {
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
    coord_t plane_offset;
  } plane_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0][CW-1:0] start;
    logic [2:0][CW-1:0] d_abs;
    logic [2:0]         qneg;
    logic [DW-1:0]      num_abs;
    logic [DW-1:0]      cos_abs;
    coord_t             start_distance;
    coord_t             end_distance;
    logic               crosses;
    status_t            status;
    logic               saturated;
  } mid_t;

  // what rides alongside the divider
  typedef struct packed {
    logic [2:0][CW-1:0] start;
    logic [2:0]         qneg;
    logic [DW-1:0]      cos_abs;
    coord_t             start_distance;
    coord_t             end_distance;
    logic               crosses;
    status_t            status;
    logic               saturated;
  } meta_t;

  typedef struct packed {
    coord_t value;
    logic   clamped;
  } clamp_t;

  function automatic logic [DW-1:0] abs_wide(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // floor shift by the fraction width, then clamp to coordinate range
  function automatic clamp_t clamp_dist(input logic signed [DW-1:0] v);
    clamp_t r;
    logic [DW-FRAC_BITS-CW:0] top;
    top = v[DW-1:FRAC_BITS+CW-1];
    if (&top || ~|top) begin
      r.value   = v[FRAC_BITS+CW-1:FRAC_BITS];
      r.clamped = 1'b0;
    end else begin
      r.value   = v[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      r.clamped = 1'b1;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- sv/psi_queue.sv -----
// small register queue between the classifying front and the dividing back
`default_nettype none
module psi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire psi_pkg::mid_t wr_data,
  output logic               full,
  input  wire logic          rd,
  output psi_pkg::mid_t      rd_data,
  output logic               empty
);
  psi_pkg::mid_t                mem [psi_pkg::QDEPTH];
  logic [psi_pkg::QAW-1:0]      wr_ptr;
  logic [psi_pkg::QAW-1:0]      rd_ptr;
  logic [psi_pkg::QAW:0]        count;

  assign full    = (count == (psi_pkg::QAW + 1)'(psi_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == psi_pkg::QAW'(psi_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == psi_pkg::QAW'(psi_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("queue read while empty");
endmodule
`default_nettype wire

// ----- sv/psi_front.sv -----
// front pipeline: plane distances, direction, and hit classification
`default_nettype none
module psi_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire psi_pkg::plane_t   plane,
  input  wire logic              push,
  output logic                   full,
  input  wire psi_pkg::segment_t segment,
  output logic                   q_wr,
  output psi_pkg::mid_t          q_data,
  input  wire logic              q_full
);
  localparam int CW = psi_pkg::CW;
  localparam int DW = psi_pkg::DW;

  logic fe;
  psi_pkg::coord_t nv [3];
  psi_pkg::coord_t in_s [3];
  psi_pkg::coord_t in_e [3];
  logic signed [DW-1:0] cterm;

  // stage a: products
  logic a_valid;
  logic signed [2*CW-1:0] a_ps [3];
  logic signed [2*CW-1:0] a_pe [3];
  logic signed [CW:0]     a_d [3];
  psi_pkg::coord_t a_s [3];
  // stage b: exact distances and direction
  logic b_valid;
  logic signed [DW-1:0] b_ds;
  logic signed [DW-1:0] b_de;
  logic signed [CW:0]   b_d [3];
  psi_pkg::coord_t b_s [3];
  // stage c
  logic c_valid;
  logic signed [DW-1:0] c_cos;
  logic [DW-1:0]        c_ds_abs;
  logic                 c_ds_zero;
  logic                 c_num_neg;
  logic [2:0][CW-1:0]   c_d_abs;
  logic [2:0]           c_d_neg;
  logic [2:0][CW-1:0]   c_s;
  psi_pkg::clamp_t      c_sd;
  psi_pkg::clamp_t      c_ed;
  logic                 c_crosses;
  // stage d
  logic d_valid;
  logic [DW-1:0]        d_cos_abs;
  logic                 d_cos_zero;
  logic                 d_cos_neg;
  logic [DW-1:0]        d_ds_abs;
  logic                 d_ds_zero;
  logic                 d_num_neg;
  logic [2:0][CW-1:0]   d_d_abs;
  logic [2:0]           d_d_neg;
  logic [2:0][CW-1:0]   d_s;
  psi_pkg::clamp_t      d_sd;
  psi_pkg::clamp_t      d_ed;
  logic                 d_crosses;

  logic ds_neg;
  logic ds_pos;
  logic de_neg;
  logic de_pos;

  assign fe   = !(d_valid && q_full);
  assign full = !fe;
  assign q_wr = d_valid && !q_full;

  assign nv[0]   = plane.normal_x;
  assign nv[1]   = plane.normal_y;
  assign nv[2]   = plane.normal_z;
  assign in_s[0] = segment.start_x;
  assign in_s[1] = segment.start_y;
  assign in_s[2] = segment.start_z;
  assign in_e[0] = segment.end_x;
  assign in_e[1] = segment.end_y;
  assign in_e[2] = segment.end_z;
  assign cterm   = DW'(plane.plane_offset) <<< psi_pkg::FRAC_BITS;

  assign ds_neg = b_ds[DW-1];
  assign ds_pos = !b_ds[DW-1] && (b_ds != '0);
  assign de_neg = b_de[DW-1];
  assign de_pos = !b_de[DW-1] && (b_de != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (fe) begin
      a_valid <= push;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < 3; i++) begin
        a_ps[i] <= (2*CW)'(nv[i]) * (2*CW)'(in_s[i]);
        a_pe[i] <= (2*CW)'(nv[i]) * (2*CW)'(in_e[i]);
        a_s[i]  <= in_s[i];
        a_d[i]  <= (CW+1)'(in_e[i]) - (CW+1)'(in_s[i]);
      end
      b_ds <= DW'(a_ps[0]) + DW'(a_ps[1]) + DW'(a_ps[2]) + cterm;
      b_de <= DW'(a_pe[0]) + DW'(a_pe[1]) + DW'(a_pe[2]) + cterm;
      for (int i = 0; i < 3; i++) begin
        b_s[i]     <= a_s[i];
        b_d[i]     <= a_d[i];
        c_d_abs[i] <= b_d[i][CW] ? CW'(-b_d[i]) : CW'(b_d[i]);
        c_d_neg[i] <= b_d[i][CW];
        c_s[i]     <= b_s[i];
      end
      c_cos     <= b_de - b_ds;
      c_ds_abs  <= psi_pkg::abs_wide(b_ds);
      c_ds_zero <= (b_ds == '0);
      c_num_neg <= ds_pos;
      c_sd      <= psi_pkg::clamp_dist(b_ds);
      c_ed      <= psi_pkg::clamp_dist(b_de);
      c_crosses <= (ds_neg && de_pos) || (ds_pos && de_neg);
      d_cos_abs  <= psi_pkg::abs_wide(c_cos);
      d_cos_zero <= (c_cos == '0);
      d_cos_neg  <= c_cos[DW-1];
      d_ds_abs   <= c_ds_abs;
      d_ds_zero  <= c_ds_zero;
      d_num_neg  <= c_num_neg;
      d_d_abs    <= c_d_abs;
      d_d_neg    <= c_d_neg;
      d_s        <= c_s;
      d_sd       <= c_sd;
      d_ed       <= c_ed;
      d_crosses  <= c_crosses;
    end
  end

  always_comb begin
    q_data.start          = d_s;
    q_data.d_abs          = d_d_abs;
    q_data.num_abs        = d_ds_abs;
    q_data.cos_abs        = d_cos_abs;
    q_data.start_distance = d_sd.value;
    q_data.end_distance   = d_ed.value;
    q_data.crosses        = d_crosses;
    q_data.saturated      = d_sd.clamped || d_ed.clamped;
    for (int i = 0; i < 3; i++) begin
      q_data.qneg[i] = d_d_neg[i] ^ d_num_neg ^ d_cos_neg;
    end
    // t in [0,1] when -ds and n.dir share sign and |ds| <= |n.dir|
    if (d_cos_zero) begin
      q_data.status = d_ds_zero ? psi_pkg::ST_ON_PLANE : psi_pkg::ST_OFF_PLANE;
    end else if (d_ds_zero || ((d_num_neg == d_cos_neg) && (d_ds_abs <= d_cos_abs))) begin
      q_data.status = psi_pkg::ST_HIT;
    end else begin
      q_data.status = psi_pkg::ST_OUTSIDE;
    end
  end
endmodule
`default_nettype wire

// ----- sv/psi_back.sv -----
// back pipeline: numerator products, one-bit-per-stage divider, hit point
`default_nettype none
module psi_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  output logic               q_rd,
  input  wire psi_pkg::mid_t q_data,
  output logic               empty,
  input  wire logic          pop,
  output psi_pkg::result_t   result
);
  localparam int CW  = psi_pkg::CW;
  localparam int DW  = psi_pkg::DW;
  localparam int PW  = psi_pkg::PW;
  localparam int NCH = psi_pkg::NCH;

  logic be;
  logic out_valid;
  logic [NCH*CW-1:0] num_pad;

  logic m_valid;
  logic [2*CW-1:0] m_pp [3][NCH];
  psi_pkg::meta_t  m_meta;
  psi_pkg::meta_t  q_meta;
  logic [PW-1:0]   prod [3];

  logic                dv_valid [CW+1];
  psi_pkg::meta_t      dv_meta  [CW+1];
  logic [2:0][DW-1:0]  dv_rem   [CW+1];
  logic [2:0][CW-1:0]  dv_lo    [CW+1];

  psi_pkg::result_t result_next;
  psi_pkg::coord_t  hit_v [3];
  logic [CW-1:0]    qs;

  assign be      = !out_valid || pop;
  assign q_rd    = be && !q_empty;
  assign empty   = !out_valid;
  assign num_pad = (NCH*CW)'(q_data.num_abs);

  always_comb begin
    q_meta.start          = q_data.start;
    q_meta.qneg           = q_data.qneg;
    q_meta.cos_abs        = q_data.cos_abs;
    q_meta.start_distance = q_data.start_distance;
    q_meta.end_distance   = q_data.end_distance;
    q_meta.crosses        = q_data.crosses;
    q_meta.status         = q_data.status;
    q_meta.saturated      = q_data.saturated;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = '0;
      for (int k = 0; k < NCH; k++) begin
        prod[i] = prod[i] + (PW'(m_pp[i][k]) << (k * CW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid     <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (be) begin
      m_valid     <= q_rd;
      dv_valid[0] <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NCH; k++) begin
          m_pp[i][k] <= (2*CW)'(q_data.d_abs[i]) * (2*CW)'(num_pad[k*CW +: CW]);
        end
        dv_rem[0][i] <= prod[i][PW-1:CW];
        dv_lo[0][i]  <= prod[i][CW-1:0];
      end
      m_meta     <= q_meta;
      dv_meta[0] <= m_meta;
    end
  end

  // restoring division, one quotient bit per stage; low word trades
  // dividend bits for quotient bits
  for (genvar j = 0; j < CW; j++) begin : g_div
    logic [2:0][DW-1:0] rem_n;
    logic [2:0][CW-1:0] lo_n;
    logic [DW:0]        trial [3];
    logic               ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dv_rem[j][i], dv_lo[j][i][CW-1]};
        ge[i]    = (trial[i] >= {1'b0, dv_meta[j].cos_abs});
        rem_n[i] = ge[i] ? DW'(trial[i] - {1'b0, dv_meta[j].cos_abs}) : trial[i][DW-1:0];
        lo_n[i]  = {dv_lo[j][i][CW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (be) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        dv_rem[j+1]  <= rem_n;
        dv_lo[j+1]   <= lo_n;
        dv_meta[j+1] <= dv_meta[j];
      end
    end
  end

  always_comb begin
    qs = '0;
    for (int i = 0; i < 3; i++) begin
      qs = dv_meta[CW].qneg[i] ? CW'(-dv_lo[CW][i]) : dv_lo[CW][i];
      case (dv_meta[CW].status)
        psi_pkg::ST_HIT:      hit_v[i] = dv_meta[CW].start[i] + qs;
        psi_pkg::ST_ON_PLANE: hit_v[i] = dv_meta[CW].start[i];
        default:              hit_v[i] = '0;
      endcase
    end
    result_next.start_distance = dv_meta[CW].start_distance;
    result_next.end_distance   = dv_meta[CW].end_distance;
    result_next.crosses        = dv_meta[CW].crosses;
    result_next.hit_x          = hit_v[0];
    result_next.hit_y          = hit_v[1];
    result_next.hit_z          = hit_v[2];
    result_next.status         = dv_meta[CW].status;
    result_next.saturated      = dv_meta[CW].saturated;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (be) begin
      out_valid <= dv_valid[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      result <= result_next;
    end
  end

  a_cross_is_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.crosses) |-> (result.status == psi_pkg::ST_HIT))
    else $error("crossing segment reported without a hit");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result.status == psi_pkg::ST_OFF_PLANE ||
                   result.status == psi_pkg::ST_OUTSIDE))
    |-> (result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0))
    else $error("hit point set for a miss");
endmodule
`default_nettype wire

// ----- sv/plane_segment_intersect.sv -----
// Segment against plane intersection, one segment per cycle.
// Configuration: APB-style port, registers normal_x, normal_y, normal_z,
// plane_offset at byte addresses 0, 4, 8, 12; writes complete in the access
// cycle, pready is tied high, reads return the stored value. All registers
// clear to zero at reset. Write them only while no segment is in flight.
// Input: a segment transaction is taken when push is high and full is low.
// Output: a result transaction is on result while empty is low and leaves on
// pop. One result per segment, in order.
// Throughput: one segment per cycle, sustained while pop keeps up.
// Path from push to result: four front stages (products, sums, distance clamp,
// classify), the queue, two product stages, a 32-stage one-bit-per-stage divider
// that sets the bulk, and the result register.
// When pop stays low the back stalls, the four-entry queue fills, then the
// front stalls and full rises; nothing is dropped.
// Reset (rst, synchronous) empties every stage and the queue.
`default_nettype none
module plane_segment_intersect (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [psi_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [psi_pkg::DATA_W-1:0]    pwdata,
  output logic [psi_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          push,
  output logic                               full,
  input  wire psi_pkg::segment_t             segment,
  output logic                               empty,
  input  wire logic                          pop,
  output psi_pkg::result_t                   result
);
  psi_pkg::plane_t   plane;
  psi_pkg::reg_idx_t reg_sel;
  logic              q_wr;
  logic              q_rd;
  logic              q_full;
  logic              q_empty;
  psi_pkg::mid_t     q_wdata;
  psi_pkg::mid_t     q_rdata;

  assign pready  = 1'b1;
  assign reg_sel = psi_pkg::reg_idx_t'(paddr[psi_pkg::ADDR_W-1:psi_pkg::STRIDE_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        psi_pkg::REG_NORMAL_X:     plane.normal_x     <= psi_pkg::CW'(pwdata);
        psi_pkg::REG_NORMAL_Y:     plane.normal_y     <= psi_pkg::CW'(pwdata);
        psi_pkg::REG_NORMAL_Z:     plane.normal_z     <= psi_pkg::CW'(pwdata);
        psi_pkg::REG_PLANE_OFFSET: plane.plane_offset <= psi_pkg::CW'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      psi_pkg::REG_NORMAL_X:     prdata = psi_pkg::DATA_W'($unsigned(plane.normal_x));
      psi_pkg::REG_NORMAL_Y:     prdata = psi_pkg::DATA_W'($unsigned(plane.normal_y));
      psi_pkg::REG_NORMAL_Z:     prdata = psi_pkg::DATA_W'($unsigned(plane.normal_z));
      psi_pkg::REG_PLANE_OFFSET: prdata = psi_pkg::DATA_W'($unsigned(plane.plane_offset));
      default:                   prdata = '0;
    endcase
  end

  psi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .plane   (plane),
    .push    (push),
    .full    (full),
    .segment (segment),
    .q_wr    (q_wr),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  psi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  psi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .q_data  (q_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );
endmodule
`default_nettype wire
